/* rtl/dhct_pkg.sv */
// Types and codes shared by the directory handle / cluster table.
package dhct_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR       = 3'd0,
    OP_ADD         = 3'd1,
    OP_DELETE      = 3'd2,
    OP_IDX_CLUSTER = 3'd3,
    OP_IDX_HANDLE  = 3'd4,
    OP_RESOLVE     = 3'd5,
    OP_READ        = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4,
    ST_DELETED   = 3'd5
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH_WAIT,
    S_DONE
  } seq_state_e;

  localparam logic [31:0] HANDLE_ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] ROOT_RESET      = 32'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] cluster_value;
    logic [31:0] handle_value;
    logic [7:0]  entry_index;
  } dhct_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_cluster;
    logic [31:0] result_link;
    logic [7:0]  result_index;
    logic [8:0]  entry_count;
  } dhct_out_t;

  // sequencer <-> table memory
  typedef struct packed {
    logic rd_en;
    logic wr_cluster;
    logic wr_link;
  } mem_ctl_t;

  // sequencer -> top level
  typedef struct packed {
    logic busy;
    logic res_vld;
  } seq_stat_t;

endpackage

/* rtl/dhct_mem.sv */
// Cluster and link stores: one write port, one registered read port.
module dhct_mem
  import dhct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int IDX_W         = 8
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_cluster,
  input  logic [31:0]      wr_link,
  output logic [31:0]      rd_cluster,
  output logic [31:0]      rd_link
);

  logic [31:0] clu_mem_r [TABLE_ENTRIES];
  logic [31:0] lnk_mem_r [TABLE_ENTRIES];
  logic [31:0] rd_cluster_r;
  logic [31:0] rd_link_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_cluster) begin
      clu_mem_r[wr_addr] <= wr_cluster;
    end
    if (ctl.wr_link) begin
      lnk_mem_r[wr_addr] <= wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_cluster_r <= clu_mem_r[rd_addr];
      rd_link_r    <= lnk_mem_r[rd_addr];
    end
  end

  assign rd_cluster = rd_cluster_r;
  assign rd_link    = rd_link_r;

endmodule

/* rtl/dhct_seq.sv */
// Sequencer: linear scan over the stores, read-modify-write and result build.
module dhct_seq
  import dhct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int IDX_W         = 8,
  parameter int CNT_W         = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  dhct_in_t         item,
  input  logic             res_rdy,
  input  logic [31:0]      root_cluster,
  output seq_stat_t        stat,
  output dhct_out_t        res,
  output mem_ctl_t         mem_ctl,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr,
  output logic [31:0]      wr_cluster,
  output logic [31:0]      wr_link,
  input  logic [31:0]      rd_cluster,
  input  logic [31:0]      rd_link
);

  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  seq_state_e state_r, state_nxt;
  logic [2:0]       op_r;
  logic [31:0]      cval_r;
  logic [31:0]      hval_r;
  logic [7:0]       eidx_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  dhct_out_t        res_r, res_nxt;

  logic key_hit;
  logic scan_done;
  logic eidx_bad;

  assign key_hit = rd_vld_r && ((op_r == OP_IDX_CLUSTER) ? (rd_cluster == cval_r)
                                                         : (rd_link == hval_r));
  // miss once every slot below the count has been issued and compared
  assign scan_done = key_hit || (!rd_vld_r && (scan_r == used_r));
  assign eidx_bad  = CMP_W'(eidx_r) >= CMP_W'(used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (op_r)
          OP_CLEAR:       state_nxt = S_DONE;
          OP_READ:        state_nxt = eidx_bad ? S_DONE : S_FETCH_WAIT;
          OP_RESOLVE:     state_nxt = (used_r == '0) ? S_DONE : S_SCAN;
          OP_ADD,
          OP_DELETE,
          OP_IDX_CLUSTER,
          OP_IDX_HANDLE:  state_nxt = S_SCAN;
          default:        state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_DONE;
      end
      S_FETCH_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (res_rdy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory controls, count update and result
  always_comb begin
    mem_ctl    = '0;
    rd_addr    = scan_r[IDX_W-1:0];
    wr_addr    = used_r[IDX_W-1:0];
    wr_cluster = cval_r;
    wr_link    = hval_r;
    used_nxt   = used_r;
    scan_nxt   = scan_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    res_nxt    = res_r;

    case (state_r)
      S_IDLE: begin
        if (start) scan_nxt = '0;
      end
      S_EXEC: begin
        res_nxt = '0;
        case (op_r)
          OP_CLEAR: begin
            used_nxt = '0;
            res_nxt.status = ST_OK;
          end
          OP_READ: begin
            if (eidx_bad) begin
              res_nxt.status = ST_INVALID;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr = IDX_W'(eidx_r);
            end
          end
          OP_RESOLVE: begin
            if (used_r == '0) begin
              if (hval_r != '0) begin
                res_nxt.status = ST_NOT_FOUND;
              end else begin
                // bootstrap: root directory goes in slot zero
                mem_ctl.wr_cluster = 1'b1;
                mem_ctl.wr_link    = 1'b1;
                wr_addr    = '0;
                wr_cluster = root_cluster;
                wr_link    = '0;
                used_nxt   = CNT_W'(1);
                res_nxt.status = (root_cluster == '0) ? ST_DELETED : ST_OK;
                res_nxt.result_cluster = root_cluster;
              end
            end
          end
          OP_ADD,
          OP_DELETE,
          OP_IDX_CLUSTER,
          OP_IDX_HANDLE: ;
          default: res_nxt.status = ST_INVALID;
        endcase
        res_nxt.entry_count = 9'(used_nxt);
      end
      S_SCAN: begin
        if (!key_hit && (scan_r < used_r)) begin
          mem_ctl.rd_en = 1'b1;
          scan_nxt   = scan_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[IDX_W-1:0];
        end
        if (scan_done) begin
          res_nxt = '0;
          if (key_hit) res_nxt.result_index = 8'(rd_idx_r);
          case (op_r)
            OP_ADD: begin
              if (key_hit) begin
                res_nxt.status = (rd_cluster != cval_r) ? ST_MISMATCH : ST_OK;
              end else if (used_r >= FULL_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_ctl.wr_cluster = 1'b1;
                mem_ctl.wr_link    = 1'b1;
                used_nxt = used_r + CNT_W'(1);
                res_nxt.status       = ST_OK;
                res_nxt.result_index = 8'(used_r[IDX_W-1:0]);
              end
            end
            OP_DELETE: begin
              if (key_hit) begin
                mem_ctl.wr_cluster = 1'b1;
                wr_addr    = rd_idx_r;
                wr_cluster = '0;
                res_nxt.status = (rd_cluster == '0) ? ST_DELETED : ST_OK;
              end else begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_IDX_CLUSTER,
            OP_IDX_HANDLE: begin
              res_nxt.status = key_hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_RESOLVE: begin
              if (!key_hit) begin
                res_nxt.status = ST_NOT_FOUND;
              end else if (rd_cluster == '0) begin
                res_nxt.status      = ST_DELETED;
                res_nxt.result_link = rd_link;
              end else begin
                res_nxt.status         = ST_OK;
                res_nxt.result_cluster = rd_cluster;
                res_nxt.result_link    = rd_link;
              end
            end
            default: res_nxt.status = ST_INVALID;
          endcase
          res_nxt.entry_count = 9'(used_nxt);
        end
      end
      S_FETCH_WAIT: begin
        res_nxt = '0;
        res_nxt.status         = (rd_cluster == '0) ? ST_DELETED : ST_OK;
        res_nxt.result_cluster = rd_cluster;
        res_nxt.result_link    = rd_link;
        res_nxt.result_index   = eidx_r;
        res_nxt.entry_count    = 9'(used_r);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
    if (start && (state_r == S_IDLE)) begin
      op_r   <= item.opcode;
      cval_r <= item.cluster_value;
      // resolve treats the all-ones handle as the root handle
      hval_r <= ((item.opcode == OP_RESOLVE) && (item.handle_value == HANDLE_ALL_ONES))
                ? '0 : item.handle_value;
      eidx_r <= item.entry_index;
    end
  end

  assign stat.busy    = (state_r != S_IDLE);
  assign stat.res_vld = (state_r == S_DONE);
  assign res          = res_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= used_r))
    else $error("scan pointer past entry count");

  a_rd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ((state_r == S_SCAN) || (state_r == S_FETCH_WAIT)))
    else $error("read data pending outside scan or fetch");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (res_r.entry_count == 9'(used_r)))
    else $error("reported count differs from table count");

endmodule

/* rtl/dir_handle_cluster_table_core.sv */
// Top level of the directory handle / cluster table.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | dhct_in_t  (opcode, operands)
//  out_    | output    | out_valid/out_stall| dhct_out_t (status, results)
//  cfg_    | input     | cfg_wr_en          | root_cluster (32 bit)
//
// One transaction at a time. Clear, unknown opcodes, failed reads and a
// resolve on an empty table go from execute straight to the result; a read
// entry waits in a fetch state for the registered read; the rest scan the
// stores linearly, one slot a cycle through the single read port.
// A finished result sits in the output register so the next transaction can
// be accepted while it waits. Reset is synchronous: count zero, no result
// pending, root_cluster 2; store contents are unknown until written.
module dir_handle_cluster_table_core
  import dhct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dhct_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dhct_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [31:0] root_cluster_r;
  logic        out_valid_r, out_valid_nxt;
  dhct_out_t   out_data_r;

  seq_stat_t        stat;
  dhct_out_t        res;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_cluster;
  logic [31:0]      wr_link;
  logic [31:0]      rd_cluster;
  logic [31:0]      rd_link;
  logic             out_free;
  logic             res_take;
  logic             accept;

  assign in_stall = stat.busy;
  assign accept   = in_valid && !stat.busy;
  assign out_free = !out_valid_r || !out_stall;
  assign res_take = stat.res_vld && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_cluster_r <= ROOT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) root_cluster_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dhct_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept),
    .item         (in_data),
    .res_rdy      (out_free),
    .root_cluster (root_cluster_r),
    .stat         (stat),
    .res          (res),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_cluster   (wr_cluster),
    .wr_link      (wr_link),
    .rd_cluster   (rd_cluster),
    .rd_link      (rd_link)
  );

  dhct_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_cluster (wr_cluster),
    .wr_link    (wr_link),
    .rd_cluster (rd_cluster),
    .rd_link    (rd_link)
  );

endmodule
